>>> rtl/core/eitc_pkg.sv
`default_nettype none
package eitc_pkg;

  // Command codes
  localparam logic CMD_EDGE     = 1'b0;
  localparam logic CMD_THROTTLE = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_STOP_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_TIMING     = 2'd1;

  // Reset values
  localparam logic [9:0]  STOP_THRESHOLD_RST = 10'd950;
  localparam logic [13:0] MAX_TIMING_RST     = 14'd1500;
  localparam logic [5:0]  CYCLE_TARGET_RST   = 6'd25;
  localparam logic [12:0] PRE_DELAY_RST      = 13'd600;
  localparam logic [13:0] SPARK_TIME_RST     = 14'd600;
  localparam logic [14:0] POST_DELAY_RST     = 15'd600;

  // Servo offset
  localparam logic [10:0] SERVO_BASE = 11'd1100;

  typedef struct packed {
    logic        command;
    logic [9:0]  throttle;
    logic [15:0] timer_now;
  } eitc_in_t;

  typedef struct packed {
    logic        engine_halt;
    logic        fire;
    logic [12:0] delay_before;
    logic [13:0] spark_length;
    logic [14:0] delay_after;
    logic [10:0] servo_duty;
  } eitc_out_t;

endpackage
`default_nettype wire

>>> rtl/core/engine_ignition_timing_controller_core.sv
// Ignition timing controller core.
// Input channel (in_valid / in_stall / in_data) carries either a throttle
// sample or a crank sensor edge stamped with the free-running timer. Every
// accepted item yields exactly one result on the output channel
// (out_valid / out_stall / out_data): stop flag, fire flag, the current
// spark timings and the servo compare value.
// The item lands in the input register, then the
// state update and result are computed and captured in the result register.
// Throughput is one item per cycle while the receiver does not stall; the only
// loop is the update of the pulse counter and timing registers between the two registers.
// Configuration (cfg_write / cfg_index / cfg_data) sets the stop threshold
// and the timing clamp; write it only while no item is in flight.
// Synchronous reset clears both pipeline stages and restores the registers
// and timing state to their defaults.
// When the receiver stalls, the result holds; the input register holds once
// the result register is full, and in_stall then rises in the same cycle.
`default_nettype none
module engine_ignition_timing_controller_core
  import eitc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire eitc_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output eitc_out_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  // configuration
  logic [9:0]  stop_threshold;
  logic [13:0] max_timing;

  // state
  logic [9:0]  throttle_level;
  logic [5:0]  pulse_count;
  logic [5:0]  cycle_target;
  logic [15:0] capture_start;
  logic [12:0] pre_delay;
  logic [13:0] spark_time;
  logic [14:0] post_delay;

  logic [9:0]  throttle_level_next;
  logic [5:0]  pulse_count_next;
  logic [5:0]  cycle_target_next;
  logic [15:0] capture_start_next;
  logic [12:0] pre_delay_next;
  logic [13:0] spark_time_next;
  logic [14:0] post_delay_next;

  // pipeline
  logic      stage_valid;
  eitc_in_t  stage_data;
  logic      out_free;
  logic      advance;
  eitc_out_t result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= STOP_THRESHOLD_RST;
      max_timing     <= MAX_TIMING_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STOP_THRESHOLD: stop_threshold <= cfg_data[9:0];
        REG_MAX_TIMING:     max_timing     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_data <= in_data;
    end
  end

  // state update for the staged item
  logic [10:0] cycle_span;
  logic [5:0]  count_inc;
  logic [15:0] elapsed;
  logic [13:0] t_raw;
  logic [13:0] t_clamp;
  logic        stopped;

  always_comb begin
    throttle_level_next = throttle_level;
    pulse_count_next    = pulse_count;
    cycle_target_next   = cycle_target;
    capture_start_next  = capture_start;
    pre_delay_next      = pre_delay;
    spark_time_next     = spark_time;
    post_delay_next     = post_delay;

    cycle_span = 11'd1024 - {1'b0, stage_data.throttle};
    count_inc  = pulse_count + 6'd1;
    elapsed    = stage_data.timer_now - capture_start;
    t_raw      = elapsed[15:2];
    t_clamp    = (t_raw == 14'd0) ? 14'd1 : t_raw;
    if (t_clamp > max_timing) t_clamp = max_timing;
    stopped    = throttle_level > stop_threshold;

    result.fire = 1'b0;

    if (stage_data.command == CMD_THROTTLE) begin
      throttle_level_next = stage_data.throttle;
      if (pulse_count == 6'd0) cycle_target_next = cycle_span[10:5];
    end else if (!stopped) begin
      pulse_count_next = count_inc;
      if (count_inc == cycle_target) capture_start_next = stage_data.timer_now;
      if ({1'b0, count_inc} == {1'b0, cycle_target} + 7'd1) begin
        pre_delay_next   = t_clamp[13:1];
        spark_time_next  = t_clamp;
        post_delay_next  = {t_clamp, 1'b0};
        pulse_count_next = 6'd0;
      end
      result.fire = pulse_count_next < cycle_target;
    end

    result.engine_halt  = throttle_level_next > stop_threshold;
    result.delay_before = pre_delay_next;
    result.spark_length = spark_time_next;
    result.delay_after  = post_delay_next;
    result.servo_duty   = {3'b000, throttle_level_next[9:2]} + SERVO_BASE;
  end

  // commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_level <= 10'd0;
      pulse_count    <= 6'd0;
      cycle_target   <= CYCLE_TARGET_RST;
      capture_start  <= 16'd0;
      pre_delay      <= PRE_DELAY_RST;
      spark_time     <= SPARK_TIME_RST;
      post_delay     <= POST_DELAY_RST;
    end else if (advance) begin
      throttle_level <= throttle_level_next;
      pulse_count    <= pulse_count_next;
      cycle_target   <= cycle_target_next;
      capture_start  <= capture_start_next;
      pre_delay      <= pre_delay_next;
      spark_time     <= spark_time_next;
      post_delay     <= post_delay_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // counter never runs past the cycle it is working towards
  assert property (@(posedge clk) disable iff (rst) pulse_count <= cycle_target)
    else $error("pulse count beyond cycle target");

  assert property (@(posedge clk) disable iff (rst) cycle_target <= 6'd32)
    else $error("cycle target out of range");

  // a spark is never requested with the engine stopped
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.fire && out_data.engine_halt))
    else $error("fire while stopped");

  // a staged item blocked by the result register is kept
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_free) |=> (stage_valid && $stable(stage_data)))
    else $error("staged item lost");
`endif

endmodule
`default_nettype wire

>>> sim/tb_engine_ignition_timing_controller_core.sv
`timescale 1ns / 1ps
module tb_engine_ignition_timing_controller_core;
  import eitc_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  eitc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  eitc_out_t   out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_STOP_THRESHOLD;
  logic [13:0] cfg_data = '0;

  // Events waiting to be driven, status reports waiting to come out
  eitc_in_t  pending_events[$];
  eitc_out_t expected_reports[$];

  // Register copies and controller state of the predictor
  logic [9:0]  threshold_q = STOP_THRESHOLD_RST;
  logic [13:0] clamp_q     = MAX_TIMING_RST;
  logic [9:0]  level_q     = '0;
  logic [5:0]  pulses_q    = '0;
  logic [5:0]  cycle_q     = CYCLE_TARGET_RST;
  logic [15:0] capture_q   = '0;
  logic [12:0] pre_q       = PRE_DELAY_RST;
  logic [13:0] spark_q     = SPARK_TIME_RST;
  logic [14:0] post_q      = POST_DELAY_RST;

  logic [15:0] stamp_clock = '0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int measure_count = 0;
  int fire_count = 0;

  engine_ignition_timing_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the controller state by one event and return its status report
  function automatic eitc_out_t predict_ignition(eitc_in_t ev);
    eitc_out_t   rep;
    logic        fire_now;
    logic [15:0] elapsed;
    logic [13:0] t;
    fire_now = 1'b0;
    if (ev.command == CMD_THROTTLE) begin
      level_q = ev.throttle;
      if (pulses_q == 6'd0) cycle_q = 6'((1024 - int'(level_q)) / 32);
    end else if (!(level_q > threshold_q)) begin
      pulses_q = pulses_q + 6'd1;
      if (pulses_q == cycle_q) capture_q = ev.timer_now;
      if (int'(pulses_q) == int'(cycle_q) + 1) begin
        elapsed = ev.timer_now - capture_q;
        t = elapsed[15:2];
        if (t == 14'd0) t = 14'd1;
        if (t > clamp_q) t = clamp_q;
        pre_q = t[13:1];
        spark_q = t;
        post_q = {t, 1'b0};
        pulses_q = 6'd0;
        measure_count++;
      end
      if (pulses_q < cycle_q) fire_now = 1'b1;
    end
    rep.engine_halt  = (level_q > threshold_q);
    rep.fire         = fire_now;
    rep.delay_before = pre_q;
    rep.spark_length = spark_q;
    rep.delay_after  = post_q;
    rep.servo_duty   = SERVO_BASE + 11'(level_q >> 2);
    return rep;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic check_report(eitc_out_t got, eitc_out_t want);
    if (got.engine_halt !== want.engine_halt)
      report_mismatch($sformatf("engine_halt %0d, want %0d",
                                got.engine_halt, want.engine_halt));
    if (got.fire !== want.fire)
      report_mismatch($sformatf("fire %0d, want %0d", got.fire, want.fire));
    if (got.delay_before !== want.delay_before)
      report_mismatch($sformatf("delay_before %0d, want %0d",
                                got.delay_before, want.delay_before));
    if (got.spark_length !== want.spark_length)
      report_mismatch($sformatf("spark_length %0d, want %0d",
                                got.spark_length, want.spark_length));
    if (got.delay_after !== want.delay_after)
      report_mismatch($sformatf("delay_after %0d, want %0d",
                                got.delay_after, want.delay_after));
    if (got.servo_duty !== want.servo_duty)
      report_mismatch($sformatf("servo_duty %0d, want %0d", got.servo_duty, want.servo_duty));
  endtask

  // Driver: present queued events, predict each one at its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_ignition(in_data));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_data  <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transferred report against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("status report with nothing expected");
        end else begin
          if (out_data.fire) fire_count++;
          check_report(out_data, expected_reports.pop_front());
          checked_count++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic eitc_in_t make_event(logic cmd, logic [9:0] lvl, logic [15:0] stamp);
    eitc_in_t ev;
    ev.command   = cmd;
    ev.throttle  = lvl;
    ev.timer_now = stamp;
    return ev;
  endfunction

  // Free-running timer: mostly short steps, now and then a jump anywhere
  function automatic logic [15:0] next_stamp();
    if ($urandom_range(0, 9) == 0) stamp_clock = 16'($urandom);
    else stamp_clock = stamp_clock + 16'($urandom_range(0, 8000));
    return stamp_clock;
  endfunction

  // Levels mostly just below the stop threshold, so cycles stay short
  function automatic logic [9:0] pick_level();
    int lo;
    if ($urandom_range(0, 99) < 15) return 10'($urandom_range(0, 1023));
    lo = (threshold_q > 10'd300) ? int'(threshold_q) - 300 : 0;
    return 10'($urandom_range(lo, int'(threshold_q)));
  endfunction

  task automatic queue_random_events(int n);
    int added;
    int roll;
    int run;
    logic [9:0] lvl;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // well-formed run: a throttle sample then about one cycle of edges
        lvl = pick_level();
        pending_events.push_back(make_event(CMD_THROTTLE, lvl, 16'($urandom)));
        run = $urandom_range(1, (1024 - int'(lvl)) / 32 + 3);
        repeat (run)
          pending_events.push_back(make_event(CMD_EDGE, 10'($urandom), next_stamp()));
        added += run + 1;
      end else if (roll < 90) begin
        pending_events.push_back(make_event(CMD_THROTTLE, 10'($urandom), 16'($urandom)));
        added++;
      end else begin
        pending_events.push_back(make_event(CMD_EDGE, 10'($urandom), 16'($urandom)));
        added++;
      end
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [13:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_STOP_THRESHOLD) threshold_q = val[9:0];
    else if (idx == REG_MAX_TIMING) clamp_q = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  // Main sequence: eight blocks, each with its own register setting, cycling through four idle/stall patterns
  initial begin
    int blk;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (blk = 0; blk < 8; blk++) begin
      if (blk > 0) begin
        wait_until_idle();
        case (blk)
          1: begin
            write_register(REG_STOP_THRESHOLD, 14'd1023);
            write_register(REG_MAX_TIMING, 14'd16383);
          end
          2: begin
            write_register(REG_STOP_THRESHOLD, 14'd0);
            write_register(REG_MAX_TIMING, 14'd1);
          end
          3: begin
            write_register(REG_STOP_THRESHOLD, 14'd600);
            write_register(REG_MAX_TIMING, 14'd0);
          end
          default: begin
            write_register(REG_STOP_THRESHOLD, 14'($urandom_range(0, 1023)));
            write_register(REG_MAX_TIMING, 14'($urandom_range(1, 16383)));
          end
        endcase
        @(negedge clk);
      end
      case (blk % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 65; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 65; end
        default: begin sender_idle_pct = 38; stall_pct = 38; end
      endcase
      if (blk == 0) begin
        // stopped engine, threshold boundary, wrapped and zero elapsed time, exact clamp
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd1023, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'hFFFF));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd950, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd100));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd200));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd199));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd951, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd0));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd0, 16'h0000));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd900, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1001));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1002));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1002));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1003));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1004));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd1005));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'd7008));
      end else if (blk == 1) begin
        // zero cycle measuring against a stale capture, then full-range timing
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd1023, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'h3FF, 16'h2AAA));
        pending_events.push_back(make_event(CMD_EDGE, 10'h000, 16'h5555));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'd990, 16'h0000));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'h0001));
        pending_events.push_back(make_event(CMD_EDGE, 10'd0, 16'h0000));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'h155, 16'hFFFF));
        pending_events.push_back(make_event(CMD_THROTTLE, 10'h2AA, 16'hFFFF));
      end
      queue_random_events(80);
    end
    wait_until_idle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d status reports never arrived", expected_reports.size()));
    $display("Drove %0d events and checked %0d reports: %0d timing measurements, %0d sparks,",
             sent_count, checked_count, measure_count, fire_count);
    $display("across eight register settings and four idle/stall patterns.");
    if (mismatch_count == 0) begin
      $display("engine_ignition_timing_controller_core test passed");
    end else begin
      $display("engine_ignition_timing_controller_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d events queued and %0d reports outstanding",
             pending_events.size(), expected_reports.size());
    $display("engine_ignition_timing_controller_core test failed");
    $finish;
  end

endmodule
